// ===== hw/rtl/gnms_pkg.sv =====
// Shared types, constants and the angle quantizer for gradient non-maximum suppression.
package gnms_pkg;

  localparam int DefaultMaxWidth   = 2048;
  localparam int DefaultQueueDepth = 4;

  localparam int RegAddrW = 3;
  localparam logic [11:0] WidthReset  = 12'd640;
  localparam logic [11:0] HeightReset = 12'd480;

  // angle thresholds in half-degree units
  localparam logic [9:0] AngFullTurn = 10'd720;
  localparam logic [9:0] AngHalfTurn = 10'd360;
  localparam logic [9:0] AngBound22  = 10'd45;
  localparam logic [9:0] AngBound67  = 10'd135;
  localparam logic [9:0] AngBound112 = 10'd225;
  localparam logic [9:0] AngBound157 = 10'd315;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_class_t;

  typedef struct packed {
    logic [15:0] grad_magnitude;
    logic [9:0]  angle_half_deg;
  } gnms_in_t;

  typedef struct packed {
    logic [15:0] kept_magnitude;
    logic [1:0]  direction_class;
    logic        frame_last;
  } gnms_out_t;

  // one candidate pixel: centre, its two neighbors along the direction, flags
  typedef struct packed {
    logic [15:0] centre;
    logic [15:0] prior;
    logic [15:0] after;
    dir_class_t  dir;
    logic        border;
    logic        last;
  } gnms_cand_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic        restart;
  } gnms_cfg_t;

  // fold modulo 180 degrees, then quantize to four classes
  function automatic dir_class_t quantize_angle(input logic [9:0] angle);
    logic [9:0] folded;
    dir_class_t cls;
    if (angle >= AngFullTurn) begin
      folded = angle - AngFullTurn;
    end else if (angle >= AngHalfTurn) begin
      folded = angle - AngHalfTurn;
    end else begin
      folded = angle;
    end
    if (folded < AngBound22 || folded >= AngBound157) begin
      cls = DIR_0;
    end else if (folded < AngBound67) begin
      cls = DIR_45;
    end else if (folded < AngBound112) begin
      cls = DIR_90;
    end else begin
      cls = DIR_135;
    end
    return cls;
  endfunction

endpackage

// ===== hw/rtl/gnms_front.sv =====
// Front end: accept, raster counters, angle classes, line store and 3x3 window.
module gnms_front #(
  parameter int MaxWidth   = gnms_pkg::DefaultMaxWidth,
  parameter int QueueDepth = gnms_pkg::DefaultQueueDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gnms_pkg::gnms_cfg_t            cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gnms_pkg::gnms_in_t             in_data,
  input  logic [$clog2(QueueDepth+1)-1:0] q_level,
  output logic                           q_push,
  output gnms_pkg::gnms_cand_t           q_data
);

  localparam int AW = $clog2(MaxWidth);
  localparam int LW = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [15:0]          older;
    logic [15:0]          newer;
    gnms_pkg::dir_class_t dir;
  } line_t;

  line_t line_mem [MaxWidth];
  line_t rd;

  logic [AW-1:0] col;
  logic [AW-1:0] col_last;
  logic [11:0]   row;
  logic [11:0]   row_last;
  logic [11:0]   h_eff;
  logic [31:0]   w_eff;
  logic [31:0]   w_m1;
  logic          col_end;
  logic          row_end;
  logic          accept;
  logic          emit;
  logic          border;

  logic                 s1_valid;
  logic [AW-1:0]        s1_col;
  logic [15:0]          s1_mag;
  gnms_pkg::dir_class_t s1_cls;
  logic                 s1_emit;
  logic                 s1_border;
  logic                 s1_last;

  logic [15:0]          win_c1 [3];
  logic [15:0]          win_c2 [3];
  gnms_pkg::dir_class_t centre_dir;

  // effective geometry
  always_comb begin
    if (cfg.frame_width < 12'd3) begin
      w_eff = 32'd3;
    end else if ({20'd0, cfg.frame_width} > 32'(MaxWidth)) begin
      w_eff = 32'(MaxWidth);
    end else begin
      w_eff = {20'd0, cfg.frame_width};
    end
    w_m1     = w_eff - 32'd1;
    col_last = w_m1[AW-1:0];
    h_eff    = (cfg.frame_height < 12'd3) ? 12'd3 : cfg.frame_height;
    row_last = h_eff - 12'd1;
  end

  assign col_end = (col == col_last);
  assign row_end = (row == row_last);
  assign emit    = (col == '0) ? (row >= 12'd3) : (row >= 12'd2);
  assign border  = (col < AW'(2));

  // the beat accepted now is held in the stage-1 registers before the queue push
  assign in_ready = !rst && ((LW+1)'(q_level) + (LW+1)'(s1_valid) < (LW+1)'(QueueDepth));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg.restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? 12'd0 : row + 12'd1;
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      centre_dir <= gnms_pkg::DIR_0;
      for (int i = 0; i < 3; i++) begin
        win_c1[i] <= '0;
        win_c2[i] <= '0;
      end
    end else begin
      s1_valid <= accept;
      if (s1_valid) begin
        for (int i = 0; i < 3; i++) begin
          win_c1[i] <= win_c2[i];
        end
        win_c2[0]  <= rd.older;
        win_c2[1]  <= rd.newer;
        win_c2[2]  <= s1_mag;
        centre_dir <= rd.dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= col;
      s1_mag    <= in_data.grad_magnitude;
      s1_cls    <= gnms_pkg::quantize_angle(in_data.angle_half_deg);
      s1_emit   <= emit;
      s1_border <= border;
      s1_last   <= row_end && col_end;
    end
  end

  // line store: read at accept, rotate the column in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd <= line_mem[col];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= '{older: rd.newer, newer: s1_mag, dir: s1_cls};
    end
  end

  // neighbors taken from the window as it stands after this shift
  always_comb begin
    q_data.centre = win_c2[1];
    q_data.dir    = centre_dir;
    q_data.border = s1_border;
    q_data.last   = s1_last;
    case (centre_dir)
      gnms_pkg::DIR_0: begin
        q_data.prior = win_c1[1];
        q_data.after = rd.newer;
      end
      gnms_pkg::DIR_45: begin
        q_data.prior = win_c1[2];
        q_data.after = rd.older;
      end
      gnms_pkg::DIR_90: begin
        q_data.prior = win_c2[0];
        q_data.after = win_c2[2];
      end
      default: begin
        q_data.prior = win_c1[0];
        q_data.after = s1_mag;
      end
    endcase
  end

  assign q_push = s1_valid && s1_emit;

endmodule

// ===== hw/rtl/gnms_queue.sv =====
// Short candidate queue between the front end and the back end.
module gnms_queue #(
  parameter int Depth = gnms_pkg::DefaultQueueDepth
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  gnms_pkg::gnms_cand_t       push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output gnms_pkg::gnms_cand_t       pop_data,
  output logic [$clog2(Depth+1)-1:0] level
);

  localparam int PW = $clog2(Depth);
  localparam int LW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LastIdx = PW'(Depth - 1);

  gnms_pkg::gnms_cand_t slots [Depth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign pop_valid = (level != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/gnms_back.sv =====
// Back end: local-maximum compare and the output register.
module gnms_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  gnms_pkg::gnms_cand_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gnms_pkg::gnms_out_t  out_data
);

  logic        keep;
  logic [15:0] kept;

  assign keep  = !q_data.border && (q_data.centre >= q_data.prior)
                 && (q_data.centre >= q_data.after);
  assign kept  = keep ? q_data.centre : 16'd0;
  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.kept_magnitude  <= kept;
      out_data.direction_class <= q_data.dir;
      out_data.frame_last      <= q_data.last;
    end
  end

endmodule

// ===== hw/rtl/gradient_non_max_suppression.sv =====
// Top level of gradient non-maximum suppression: register port, front, queue, back.
//
//   channel   dir   handshake                   beat
//   in        in    in_valid / in_ready          gnms_in_t  (magnitude, half-degree angle)
//   out       out   out_valid / out_ready        gnms_out_t (kept magnitude, class, last)
//   apb       in    psel, penable, pwrite        frame_width @0x0, frame_height @0x4
//
// One pixel beat per clock sustained while the output does not stall; the line
// store (one read and one write port) sets that figure. An accepted beat reads
// the line store into the stage-1 registers, shifts the window into the queue,
// and is loaded into the output register when the back end pops it.
// rst is synchronous; line stores are not cleared and need no clearing pass.
// A stalled output fills the 4-entry queue; in_ready drops when the queue plus
// the beat in the window stage could overflow it.
// Any register write restarts the frame at row 0, column 0.
module gradient_non_max_suppression #(
  parameter int MaxWidth   = gnms_pkg::DefaultMaxWidth,
  parameter int QueueDepth = gnms_pkg::DefaultQueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gnms_pkg::gnms_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gnms_pkg::gnms_out_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gnms_pkg::RegAddrW-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int LW = $clog2(QueueDepth + 1);

  logic [11:0]          frame_width;
  logic [11:0]          frame_height;
  logic                 reg_write;
  gnms_pkg::reg_index_t reg_index;
  gnms_pkg::gnms_cfg_t  cfg;

  logic                 q_push;
  gnms_pkg::gnms_cand_t q_push_data;
  logic                 q_pop;
  logic                 q_valid;
  gnms_pkg::gnms_cand_t q_pop_data;
  logic [LW-1:0]        q_level;

  // register port: word-aligned, decode on the word index bit only
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;
  assign reg_index = gnms_pkg::reg_index_t'(paddr[gnms_pkg::RegAddrW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gnms_pkg::WidthReset;
      frame_height <= gnms_pkg::HeightReset;
    end else if (reg_write) begin
      case (reg_index)
        gnms_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[11:0];
        gnms_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      gnms_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, frame_width};
      gnms_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, frame_height};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg.frame_width  = frame_width;
  assign cfg.frame_height = frame_height;
  assign cfg.restart      = reg_write;

  // front: counters, classes, line store, window
  gnms_front #(
    .MaxWidth   (MaxWidth),
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // decouples window stage from output stalls
  gnms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_pop_data),
    .level     (q_level)
  );

  // back: compare and output register
  gnms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // the credit check on in_ready must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_level < LW'(QueueDepth)))
    else $error("candidate queue overflow");

  // a candidate only appears in the cycle after a pixel beat was taken
  a_push_follows_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> $past(in_valid && in_ready))
    else $error("queue push without a preceding input beat");

  // input stalls only while something is held in the pipe
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    (!rst && !in_ready) |-> (q_level != '0) || $past(in_valid && in_ready))
    else $error("input stalled with an empty pipe");
`endif

endmodule
